>>> rtl/core/mtqs_pkg.sv
// package: record word types, sequencer states and key compare for the sort engine
package mtqs_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 6;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             final_res;
  } out_word_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
  } rec_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_MED_A,
    ST_MED_B,
    ST_MED_C,
    ST_MED_X,
    ST_MED_WM,
    ST_MED_WH,
    ST_PL,
    ST_PL_CK,
    ST_PR,
    ST_PR_CK,
    ST_PDEC,
    ST_PSW,
    ST_PEND,
    ST_MIN_INIT,
    ST_MIN_V0,
    ST_MIN_RD,
    ST_MIN_CK,
    ST_MIN_SW,
    ST_MIN_SW2,
    ST_INS_INIT,
    ST_INS_RD,
    ST_INS_K,
    ST_INS_T,
    ST_INS_TC,
    ST_INS_Z,
    ST_INS_NX,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_W
  } state_e;

  function automatic logic goes_before(input logic desc, input rec_t a, input rec_t b);
    goes_before = desc ? (a.key > b.key) : (a.key < b.key);
  endfunction

endpackage

>>> rtl/core/median_three_quicksort_engine.sv
// top level: record buffer in ram with a median-of-three quicksort and insertion sort sequencer
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    mtqs_pkg::in_word_t
//  out       output     out_valid/out_ready  mtqs_pkg::out_word_t
//  cfg       input      cfg_we               cfg_wdata (descending)
//
// records load one per cycle while the block is in its load state.
// the sort after a last word runs on the single ram read port, and the run length
// depends on the data.
// each sorted word is read from the ram, registered, then held until out_ready takes it.
// reset is asynchronous and active low; the ram itself is not cleared.
module median_three_quicksort_engine #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned THRESHOLD   = 4,
  parameter int unsigned STACK_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mtqs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mtqs_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  import mtqs_pkg::*;

  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned CW  = IW + 1;
  localparam int unsigned SW  = ((IW > 5) ? IW : 5) + 2;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIW = $clog2(STACK_DEPTH);
  localparam int unsigned RW  = $bits(rec_t);
  localparam logic signed [SW-1:0] TH_S = SW'(THRESHOLD);

  state_e state_q, state_d;
  logic   desc_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [SW-1:0] l_q, l_d, r_q, r_d;
  rec_t a_q, a_d, b_q, b_d, c_q, c_d, piv_q, piv_d, x_q, x_d, y_q, y_d;
  logic [IW-1:0] i_q, i_d, m_q, m_d, t_q, t_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [SIW-1:0] sp_top;
  logic [2*IW-1:0] stk_q [STACK_DEPTH];
  logic            push;
  logic [2*IW-1:0] push_val;
  out_word_t out_q, out_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  rec_t          ram_wdata, rdata;
  logic [RW-1:0] rdata_raw;

  logic [IW-1:0] mid_w;
  logic [CW-1:0] n_ld, end_w;
  logic [IW-1:0] th_w;
  logic signed [SW-1:0] lo_s, hi_s, dl, dh;
  rec_t ma1, mb1, mb2, mc2, ma3, mb3;
  logic in_acc, out_acc;

  mtqs_ram #(
    .WIDTH(RW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata_raw)
  );

  assign rdata   = rec_t'(rdata_raw);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign mid_w   = lo_q + ((hi_q - lo_q) >> 1);
  assign n_ld    = (cnt_q < CW'(CAPACITY)) ? cnt_q + CW'(1) : cnt_q;
  assign end_w   = cnt_q - CW'(1);
  assign th_w    = (int'(end_w) < THRESHOLD) ? end_w[IW-1:0] : IW'(THRESHOLD);
  assign lo_s    = signed'({{(SW-IW){1'b0}}, lo_q});
  assign hi_s    = signed'({{(SW-IW){1'b0}}, hi_q});
  assign dl      = r_q - lo_s;
  assign dh      = hi_s - l_q;
  assign sp_top  = SIW'(sp_q - SPW'(1));

  // median of three on lo, mid (registered) and hi (ram read data)
  always_comb begin
    ma1 = a_q;
    mb1 = b_q;
    if (goes_before(desc_q, b_q, a_q)) begin
      ma1 = b_q;
      mb1 = a_q;
    end
    mb2 = mb1;
    mc2 = rdata;
    ma3 = ma1;
    mb3 = mb1;
    if (goes_before(desc_q, rdata, mb1)) begin
      mb2 = rdata;
      mc2 = mb1;
      mb3 = mb2;
      if ((lo_q != mid_w) && goes_before(desc_q, mb2, ma1)) begin
        ma3 = mb2;
        mb3 = ma1;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    l_d      = l_q;
    r_d      = r_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    piv_d    = piv_q;
    x_d      = x_q;
    y_d      = y_q;
    i_d      = i_q;
    m_d      = m_q;
    t_d      = t_q;
    sp_d     = sp_q;
    push     = 1'b0;
    push_val = '0;
    out_d    = out_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          cnt_d = n_ld;
          if (in_word_i.last) begin
            lo_d = '0;
            hi_d = IW'(n_ld - CW'(1));
            sp_d = '0;
            cnt_d = n_ld;
            state_d = (int'(n_ld) > THRESHOLD) ? ST_MED_A : ST_MIN_INIT;
          end
        end
      end
      ST_MED_A: state_d = ST_MED_B;
      ST_MED_B: begin
        a_d = rdata;
        state_d = ST_MED_C;
      end
      ST_MED_C: begin
        b_d = rdata;
        state_d = ST_MED_X;
      end
      ST_MED_X: begin
        b_d = mb3;
        c_d = mc2;
        a_d = ma3;
        state_d = ST_MED_WM;
      end
      ST_MED_WM: state_d = ST_MED_WH;
      ST_MED_WH: begin
        piv_d = b_q;
        l_d = lo_s + SW'(1);
        r_d = hi_s - SW'(1);
        state_d = ST_PL;
      end
      ST_PL: state_d = (l_q < hi_s) ? ST_PL_CK : ST_PR;
      ST_PL_CK: begin
        x_d = rdata;
        if (goes_before(desc_q, rdata, piv_q)) begin
          l_d = l_q + SW'(1);
          state_d = ST_PL;
        end else begin
          state_d = ST_PR;
        end
      end
      ST_PR: state_d = (r_q > lo_s) ? ST_PR_CK : ST_PDEC;
      ST_PR_CK: begin
        y_d = rdata;
        if (goes_before(desc_q, piv_q, rdata)) begin
          r_d = r_q - SW'(1);
          state_d = ST_PR;
        end else begin
          state_d = ST_PDEC;
        end
      end
      ST_PDEC: begin
        if (l_q < r_q) begin
          state_d = ST_PSW;
        end else if (l_q == r_q) begin
          l_d = l_q + SW'(1);
          r_d = r_q - SW'(1);
          state_d = ST_PEND;
        end else begin
          state_d = ST_PEND;
        end
      end
      ST_PSW: begin
        l_d = l_q + SW'(1);
        r_d = r_q - SW'(1);
        state_d = ((l_q + SW'(1)) <= (r_q - SW'(1))) ? ST_PL : ST_PEND;
      end
      ST_PEND: begin
        state_d = ST_MED_A;
        if (dl <= TH_S) begin
          if (dh <= TH_S) begin
            if (sp_q == '0) begin
              state_d = ST_MIN_INIT;
            end else begin
              sp_d = sp_q - SPW'(1);
              lo_d = stk_q[sp_top][2*IW-1:IW];
              hi_d = stk_q[sp_top][IW-1:0];
            end
          end else begin
            lo_d = l_q[IW-1:0];
          end
        end else if (dh <= TH_S) begin
          hi_d = r_q[IW-1:0];
        end else if (dl > dh) begin
          if (sp_q < SPW'(STACK_DEPTH)) begin
            push = 1'b1;
            push_val = {lo_q, r_q[IW-1:0]};
            sp_d = sp_q + SPW'(1);
          end
          lo_d = l_q[IW-1:0];
        end else begin
          if (sp_q < SPW'(STACK_DEPTH)) begin
            push = 1'b1;
            push_val = {l_q[IW-1:0], hi_q};
            sp_d = sp_q + SPW'(1);
          end
          hi_d = r_q[IW-1:0];
        end
      end
      ST_MIN_INIT: state_d = ST_MIN_V0;
      ST_MIN_V0: begin
        x_d = rdata;
        y_d = rdata;
        m_d = '0;
        i_d = IW'(1);
        state_d = (th_w == '0) ? ST_INS_INIT : ST_MIN_RD;
      end
      ST_MIN_RD: state_d = ST_MIN_CK;
      ST_MIN_CK: begin
        if (goes_before(desc_q, rdata, y_q)) begin
          y_d = rdata;
          m_d = i_q;
        end
        if (i_q == th_w) begin
          state_d = ST_MIN_SW;
        end else begin
          i_d = i_q + IW'(1);
          state_d = ST_MIN_RD;
        end
      end
      ST_MIN_SW: state_d = (m_q != '0) ? ST_MIN_SW2 : ST_INS_INIT;
      ST_MIN_SW2: state_d = ST_INS_INIT;
      ST_INS_INIT: begin
        if (int'(end_w) < 2) begin
          i_d = '0;
          state_d = ST_OUT_RD;
        end else begin
          i_d = IW'(2);
          state_d = ST_INS_RD;
        end
      end
      ST_INS_RD: state_d = ST_INS_K;
      ST_INS_K: begin
        a_d = rdata;
        t_d = i_q - IW'(1);
        state_d = ST_INS_T;
      end
      ST_INS_T: state_d = ST_INS_TC;
      ST_INS_TC: begin
        if (goes_before(desc_q, a_q, rdata)) begin
          if (t_q == '0) begin
            state_d = ST_INS_Z;
          end else begin
            t_d = t_q - IW'(1);
            state_d = ST_INS_T;
          end
        end else begin
          state_d = ST_INS_NX;
        end
      end
      ST_INS_Z: state_d = ST_INS_NX;
      ST_INS_NX: begin
        if (i_q == end_w[IW-1:0]) begin
          i_d = '0;
          state_d = ST_OUT_RD;
        end else begin
          i_d = i_q + IW'(1);
          state_d = ST_INS_RD;
        end
      end
      ST_OUT_RD: state_d = ST_OUT_LD;
      ST_OUT_LD: begin
        out_d.sorted_key = rdata.key;
        out_d.sorted_tag = rdata.tag;
        out_d.final_res  = (i_q == end_w[IW-1:0]);
        state_d = ST_OUT_W;
      end
      ST_OUT_W: begin
        if (out_acc) begin
          if (out_q.final_res) begin
            cnt_d = '0;
            state_d = ST_LOAD;
          end else begin
            i_d = i_q + IW'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_LOAD);
    out_valid_o = (state_q == ST_OUT_W);
    out_word_o  = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = a_q;
    ram_raddr   = '0;
    unique case (state_q)
      ST_LOAD: begin
        ram_we    = in_acc && (cnt_q < CW'(CAPACITY));
        ram_waddr = cnt_q[IW-1:0];
        ram_wdata = '{tag: in_word_i.tag, key: in_word_i.key};
      end
      ST_MED_A:  ram_raddr = lo_q;
      ST_MED_B:  ram_raddr = mid_w;
      ST_MED_C:  ram_raddr = hi_q;
      ST_MED_X: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = ma3;
      end
      ST_MED_WM: begin
        ram_we    = 1'b1;
        ram_waddr = mid_w;
        ram_wdata = b_q;
      end
      ST_MED_WH: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = c_q;
      end
      ST_PL:     ram_raddr = l_q[IW-1:0];
      ST_PR:     ram_raddr = r_q[IW-1:0];
      ST_PDEC: begin
        ram_we    = (l_q < r_q);
        ram_waddr = l_q[IW-1:0];
        ram_wdata = y_q;
      end
      ST_PSW: begin
        ram_we    = 1'b1;
        ram_waddr = r_q[IW-1:0];
        ram_wdata = x_q;
      end
      ST_MIN_RD: ram_raddr = i_q;
      ST_MIN_SW: begin
        ram_we    = (m_q != '0);
        ram_waddr = '0;
        ram_wdata = y_q;
      end
      ST_MIN_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = m_q;
        ram_wdata = x_q;
      end
      ST_INS_RD: ram_raddr = i_q;
      ST_INS_T:  ram_raddr = t_q;
      ST_INS_TC: begin
        ram_we    = 1'b1;
        ram_waddr = t_q + IW'(1);
        ram_wdata = goes_before(desc_q, a_q, rdata) ? rdata : a_q;
      end
      ST_INS_Z: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = a_q;
      end
      ST_OUT_RD: ram_raddr = i_q;
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      desc_q  <= 1'b1;
      cnt_q   <= '0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sp_q    <= sp_d;
      if (cfg_we_i) begin
        desc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    l_q   <= l_d;
    r_q   <= r_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    piv_q <= piv_d;
    x_q   <= x_d;
    y_q   <= y_d;
    i_q   <= i_d;
    m_q   <= m_d;
    t_q   <= t_d;
    out_q <= out_d;
    if (push) begin
      stk_q[sp_q[SIW-1:0]] <= push_val;
    end
  end

  sp_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("partition stack pointer past depth");

  cnt_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("record count past capacity");

  side_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("loading and emitting at once");

  final_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_word_o.final_res) |=> (in_ready_o && cnt_q == '0))
    else $error("no return to load after final word");

endmodule

>>> rtl/core/mtqs_ram.sv
// generic single write, single read ram with registered read data
module mtqs_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
